// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, constants and voice tables of the polymetric step sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int LANE_COUNT_DEF = 5;
    localparam int MAX_STEPS_DEF  = 32;
    localparam int STEP_BITS_DEF  = 16;

    localparam int CMD_W      = 2;
    localparam int LANE_W     = 3;
    localparam int CELL_SEL_W = 5;
    localparam int LEAD_W     = 9;
    localparam int SPLICE_W   = 4;
    localparam int LEN_IN_W   = 6;
    localparam int STEP_OUT_W = 5;
    localparam int DELAY_W    = 9;
    localparam int NOTE_W     = 7;
    localparam int SLOT_W     = 4;
    localparam int VEL_W      = 3;
    localparam int DUR_W      = 10;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CELL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LANE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd3;

    localparam logic [SPLICE_W-1:0] SPLICE_MAX = 4'd14;
    localparam logic [DELAY_W-1:0]  DELAY_MAX  = 9'd511;
    localparam logic [SLOT_W-1:0]   SLOT_BASE  = 4'd9;
    localparam logic [LANE_W-1:0]   PIPS_LANE  = 3'd2;
    localparam logic [DUR_W-1:0]    PIPS_DUR_DOWN  = 10'd300;
    localparam logic [DUR_W-1:0]    PIPS_DUR_OTHER = 10'd70;

    // width of a stored loop length; reset lengths reach 32
    function automatic int len_width(input int max_steps);
        return $clog2(((max_steps > 32) ? max_steps : 32) + 1);
    endfunction

    function automatic int cell_width(input int max_steps);
        return (max_steps > 2) ? $clog2(max_steps) : 1;
    endfunction

    function automatic int lane_idx_width(input int lane_count);
        return (lane_count > 1) ? $clog2(lane_count) : 1;
    endfunction

    typedef struct packed {
        logic                  cell_we;
        logic                  len_we;
        logic [LANE_W-1:0]     lane;
        logic [CELL_SEL_W-1:0] cell_idx;
        logic                  hit;
        logic [SPLICE_W-1:0]   splice;
        logic [LEN_IN_W-1:0]   len;
        logic                  mute;
    } t_wr_req;

    function automatic logic [NOTE_W-1:0] lane_note(input logic [LANE_W-1:0] lane);
        logic [NOTE_W-1:0] v;
        unique case (lane)
            3'd0:    v = 7'd36;
            3'd1:    v = 7'd79;
            3'd2:    v = 7'd84;
            3'd3:    v = 7'd96;
            3'd4:    v = 7'd70;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VEL_W-1:0] lane_vel(input logic [LANE_W-1:0] lane);
        logic [VEL_W-1:0] v;
        unique case (lane)
            3'd0:    v = 3'd6;
            3'd1:    v = 3'd4;
            3'd2:    v = 3'd3;
            3'd3:    v = 3'd3;
            3'd4:    v = 3'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [DUR_W-1:0] lane_dur(input logic [LANE_W-1:0] lane);
        logic [DUR_W-1:0] v;
        unique case (lane)
            3'd0:    v = 10'd130;
            3'd1:    v = 10'd200;
            3'd2:    v = 10'd70;
            3'd3:    v = 10'd25;
            3'd4:    v = 10'd620;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [LEN_IN_W-1:0] lane_len0(input logic [LANE_W-1:0] lane);
        logic [LEN_IN_W-1:0] v;
        unique case (lane)
            3'd1:    v = 6'd5;
            3'd2:    v = 6'd7;
            3'd3:    v = 6'd11;
            3'd4:    v = 6'd32;
            default: v = 6'd16;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/polymetric_step_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// polymetric_step_sequencer_core
// Five-lane polymetric step sequencer: stores cell and lane writes and, on
// each new tick, walks the lanes through one shared modulo unit to emit hits.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  command   | in        | i_valid / o_ready  | i_cmd .. i_run_on
//  hit       | out       | o_valid / i_ready  | o_hit_lane .. o_last
//
//  Writes and run control are taken in the idle state. A tick that fires
//  walks, per lane and pass, through the modulo start, the shared modulo unit
//  and the lane check, plus a splice memory read for each hit, then a flush
//  state; the lanes get a second pass on the first tick after start.
//  Reset is synchronous; the pattern bits clear at once, no clearing pass.
//  A stalled hit output holds the sequencer once the output register and the
//  parked hit are both full.
// ----------------------------------------------------------------------------
module polymetric_step_sequencer_core #(
    parameter int LANE_COUNT = pss_pkg::LANE_COUNT_DEF,
    parameter int MAX_STEPS  = pss_pkg::MAX_STEPS_DEF,
    parameter int STEP_BITS  = pss_pkg::STEP_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [pss_pkg::CMD_W-1:0]          i_cmd,
    input  logic [STEP_BITS-1:0]               i_step_count,
    input  logic [pss_pkg::LEAD_W-1:0]         i_lead_ms,
    input  logic [pss_pkg::LANE_W-1:0]         i_lane_sel,
    input  logic [pss_pkg::CELL_SEL_W-1:0]     i_cell_sel,
    input  logic                               i_hit_bit,
    input  logic [pss_pkg::SPLICE_W-1:0]       i_splice_ms,
    input  logic [pss_pkg::LEN_IN_W-1:0]       i_loop_length,
    input  logic                               i_mute_bit,
    input  logic                               i_run_on,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pss_pkg::LANE_W-1:0]         o_hit_lane,
    output logic [pss_pkg::STEP_OUT_W-1:0]     o_lane_step,
    output logic [pss_pkg::DELAY_W-1:0]        o_delay_ms,
    output logic [pss_pkg::NOTE_W-1:0]         o_note,
    output logic [pss_pkg::SLOT_W-1:0]         o_voice_slot,
    output logic [pss_pkg::VEL_W-1:0]          o_velocity,
    output logic [pss_pkg::DUR_W-1:0]          o_duration_ms,
    output logic                               o_last
);

    localparam int LEN_W  = pss_pkg::len_width(MAX_STEPS);
    localparam int LIDX_W = pss_pkg::lane_idx_width(LANE_COUNT);
    localparam int HIT_W  = pss_pkg::LANE_W + pss_pkg::STEP_OUT_W + pss_pkg::DELAY_W
                            + pss_pkg::NOTE_W + pss_pkg::SLOT_W + pss_pkg::VEL_W
                            + pss_pkg::DUR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic                        r_run, n_run;
    logic                        r_first_pend, n_first_pend;
    logic                        r_first, n_first;
    logic                        r_pass, n_pass;
    logic [pss_pkg::LANE_W-1:0]  r_lane, n_lane;
    logic [STEP_BITS-1:0]        r_prev, n_prev;
    logic [STEP_BITS-1:0]        r_s, n_s;
    logic [STEP_BITS-1:0]        r_nx, n_nx;
    logic [pss_pkg::LEAD_W-1:0]  r_lead, n_lead;
    logic [LEN_W-1:0]            r_st, n_st;
    logic                        r_pend_v, n_pend_v;
    logic [HIT_W-1:0]            r_pend, n_pend;
    logic                        r_out_v, n_out_v;
    logic [HIT_W-1:0]            r_out, n_out;
    logic                        r_out_last, n_out_last;

    pss_pkg::t_wr_req            wr;
    logic                        accept;
    logic                        out_free;
    logic                        lane_ok;
    logic                        cell_ok;
    logic                        mod_start;
    logic                        mod_done;
    logic [LEN_W-1:0]            mod_rem;
    logic [LEN_W-1:0]            lane_len;
    logic                        cell_on;
    logic                        sp_rd;
    logic [pss_pkg::SPLICE_W-1:0] splice;
    logic [pss_pkg::DELAY_W:0]   dsum;
    logic [pss_pkg::DELAY_W-1:0] delay;
    logic [pss_pkg::DUR_W-1:0]   dur;
    logic [HIT_W-1:0]            hit;
    logic                        lane_end;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_v || i_ready;
    assign lane_ok  = {1'b0, i_lane_sel} < 4'(LANE_COUNT);
    assign cell_ok  = 7'(i_cell_sel) < 7'(MAX_STEPS);
    assign lane_end = (r_lane == pss_pkg::LANE_W'(LANE_COUNT - 1));

    always_comb begin
        wr          = '0;
        wr.lane     = i_lane_sel;
        wr.cell_idx = i_cell_sel;
        wr.hit      = i_hit_bit;
        wr.splice   = i_splice_ms;
        wr.len      = i_loop_length;
        wr.mute     = i_mute_bit;
        wr.cell_we  = accept && (i_cmd == pss_pkg::CMD_CELL) && lane_ok && cell_ok;
        wr.len_we   = accept && (i_cmd == pss_pkg::CMD_LANE) && lane_ok;
    end

    pss_lane_store #(
        .LANE_COUNT (LANE_COUNT),
        .MAX_STEPS  (MAX_STEPS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_lane (LIDX_W'(r_lane)),
        .i_rd_step (r_st),
        .i_sp_rd   (sp_rd),
        .o_len     (lane_len),
        .o_cell_on (cell_on),
        .o_splice  (splice)
    );

    pss_mod_unit #(
        .STEP_BITS (STEP_BITS),
        .MAX_STEPS (MAX_STEPS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_pass ? r_s : r_nx),
        .i_divisor  (lane_len),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // hit record for the lane under test
    assign dsum = {1'b0, r_lead} + (pss_pkg::DELAY_W + 1)'(splice);
    always_comb begin
        if (r_pass) begin
            delay = '0;
        end else if (dsum > {1'b0, pss_pkg::DELAY_MAX}) begin
            delay = pss_pkg::DELAY_MAX;
        end else begin
            delay = pss_pkg::DELAY_W'(dsum);
        end
        if (r_lane == pss_pkg::PIPS_LANE) begin
            dur = (r_st == '0) ? pss_pkg::PIPS_DUR_DOWN : pss_pkg::PIPS_DUR_OTHER;
        end else begin
            dur = pss_pkg::lane_dur(r_lane);
        end
    end

    assign hit = {r_lane, pss_pkg::STEP_OUT_W'(r_st), delay, pss_pkg::lane_note(r_lane),
                  pss_pkg::SLOT_W'(pss_pkg::SLOT_BASE + pss_pkg::SLOT_W'(r_lane)),
                  pss_pkg::lane_vel(r_lane), dur};

    always_comb begin
        n_state      = r_state;
        n_run        = r_run;
        n_first_pend = r_first_pend;
        n_first      = r_first;
        n_pass       = r_pass;
        n_lane       = r_lane;
        n_prev       = r_prev;
        n_s          = r_s;
        n_nx         = r_nx;
        n_lead       = r_lead;
        n_st         = r_st;
        n_pend_v     = r_pend_v;
        n_pend       = r_pend;
        n_out_v      = r_out_v && !i_ready;
        n_out        = r_out;
        n_out_last   = r_out_last;
        mod_start    = 1'b0;
        sp_rd        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        pss_pkg::CMD_TICK: begin
                            if (r_run && (r_first_pend || (i_step_count != r_prev))) begin
                                n_prev       = i_step_count;
                                n_first_pend = 1'b0;
                                n_first      = r_first_pend;
                                n_s          = i_step_count;
                                n_nx         = i_step_count + 1'b1;
                                n_lead       = i_lead_ms;
                                n_pass       = 1'b0;
                                n_lane       = '0;
                                n_state      = S_START;
                            end
                        end
                        pss_pkg::CMD_RUN: begin
                            n_run        = i_run_on;
                            n_first_pend = 1'b1;
                        end
                        pss_pkg::CMD_CELL, pss_pkg::CMD_LANE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_START: begin
                mod_start = 1'b1;
                n_state   = S_MOD;
            end
            S_MOD: begin
                if (mod_done) begin
                    n_st    = mod_rem;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (cell_on) begin
                    sp_rd   = 1'b1;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_pend_v) begin
                    n_pend_v = 1'b1;
                    n_pend   = hit;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b0;
                    n_pend     = hit;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // lane advance after a miss, or after the hit is parked
        if ((r_state == S_CHECK && !cell_on)
            || (r_state == S_PUSH && (!r_pend_v || out_free))) begin
            if (!lane_end) begin
                n_lane  = r_lane + 1'b1;
                n_state = S_START;
            end else if (!r_pass && r_first) begin
                n_pass  = 1'b1;
                n_lane  = '0;
                n_state = S_START;
            end else begin
                n_state = S_FLUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run        <= 1'b0;
            r_first_pend <= 1'b1;
            r_first      <= 1'b0;
            r_pass       <= 1'b0;
            r_lane       <= '0;
            r_prev       <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_first_pend <= n_first_pend;
            r_first      <= n_first;
            r_pass       <= n_pass;
            r_lane       <= n_lane;
            r_prev       <= n_prev;
            r_pend_v     <= n_pend_v;
            r_out_v      <= n_out_v;
        end
        r_s        <= n_s;
        r_nx       <= n_nx;
        r_lead     <= n_lead;
        r_st       <= n_st;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_v;
    assign o_last  = r_out_last;
    assign {o_hit_lane, o_lane_step, o_delay_ms, o_note, o_voice_slot, o_velocity,
            o_duration_ms} = r_out;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending hit left behind");

    a_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_MOD))
        else $error("modulo result outside wait state");

    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_hit_lane} < 4'(LANE_COUNT)))
        else $error("hit on a lane that does not exist");

    a_push_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> ($past(r_state) == S_CHECK || $past(r_state) == S_PUSH))
        else $error("hit formed without splice read");

endmodule

// ===== rtl/pss_mod_unit.sv =====
// ----------------------------------------------------------------------------
// pss_mod_unit
// Shared restoring remainder unit: step index modulo loop length, one bit
// per cycle.
// ----------------------------------------------------------------------------
module pss_mod_unit #(
    parameter int STEP_BITS = pss_pkg::STEP_BITS_DEF,
    parameter int MAX_STEPS = pss_pkg::MAX_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [STEP_BITS-1:0] i_dividend,
    input  logic [pss_pkg::len_width(MAX_STEPS)-1:0] i_divisor,
    output logic                 o_done,
    output logic [pss_pkg::len_width(MAX_STEPS)-1:0] o_rem
);

    localparam int LEN_W = pss_pkg::len_width(MAX_STEPS);
    localparam int CNT_W = $clog2(STEP_BITS);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [STEP_BITS-1:0] r_dvd, n_dvd;
    logic [LEN_W-1:0]     r_div, n_div;
    logic [LEN_W-1:0]     r_rem, n_rem;
    logic [LEN_W:0]       trial;

    assign trial = {r_rem, r_dvd[STEP_BITS-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(STEP_BITS - 1);
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[STEP_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem = LEN_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = LEN_W'(trial);
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < r_div))
        else $error("remainder not below divisor");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("start while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("done without work");

endmodule

// ===== rtl/pss_lane_store.sv =====
// ----------------------------------------------------------------------------
// pss_lane_store
// Pattern bits, per-cell splice memory, loop lengths and mutes of all lanes.
// ----------------------------------------------------------------------------
module pss_lane_store #(
    parameter int LANE_COUNT = pss_pkg::LANE_COUNT_DEF,
    parameter int MAX_STEPS  = pss_pkg::MAX_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pss_pkg::t_wr_req i_wr,
    input  logic [pss_pkg::lane_idx_width(LANE_COUNT)-1:0] i_rd_lane,
    input  logic [pss_pkg::len_width(MAX_STEPS)-1:0]       i_rd_step,
    input  logic             i_sp_rd,
    output logic [pss_pkg::len_width(MAX_STEPS)-1:0]       o_len,
    output logic             o_cell_on,
    output logic [pss_pkg::SPLICE_W-1:0] o_splice
);

    localparam int LEN_W  = pss_pkg::len_width(MAX_STEPS);
    localparam int CW     = pss_pkg::cell_width(MAX_STEPS);
    localparam int LIDX_W = pss_pkg::lane_idx_width(LANE_COUNT);
    localparam int DEPTH  = LANE_COUNT * (2 ** CW);

    logic [MAX_STEPS-1:0]         r_pat [LANE_COUNT];
    logic [LEN_W-1:0]             r_len [LANE_COUNT];
    logic [LANE_COUNT-1:0]        r_mute;
    logic [pss_pkg::SPLICE_W-1:0] r_mem [DEPTH];
    logic [pss_pkg::SPLICE_W-1:0] r_splice;

    logic [LIDX_W-1:0]            wr_lane;
    logic [CW-1:0]                wr_cell;
    logic [pss_pkg::SPLICE_W-1:0] wr_splice;
    logic [LEN_W-1:0]             wr_len;
    logic [LEN_W-1:0]             len_in;
    logic [LIDX_W+CW-1:0]         wr_addr;
    logic [LIDX_W+CW-1:0]         rd_addr;

    assign wr_lane   = LIDX_W'(i_wr.lane);
    assign wr_cell   = CW'(i_wr.cell_idx);
    assign wr_addr   = {wr_lane, wr_cell};
    assign rd_addr   = {i_rd_lane, CW'(i_rd_step)};
    assign wr_splice = (i_wr.splice > pss_pkg::SPLICE_MAX) ? pss_pkg::SPLICE_MAX
                                                           : i_wr.splice;
    assign len_in    = LEN_W'(i_wr.len);

    always_comb begin
        priority if (len_in < LEN_W'(2)) begin
            wr_len = LEN_W'(2);
        end else if (len_in > LEN_W'(MAX_STEPS)) begin
            wr_len = LEN_W'(MAX_STEPS);
        end else begin
            wr_len = len_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANE_COUNT; l++) begin
                r_pat[l] <= '0;
                r_len[l] <= LEN_W'(pss_pkg::lane_len0(pss_pkg::LANE_W'(l)));
            end
            r_mute <= '0;
        end else begin
            if (i_wr.cell_we) begin
                r_pat[wr_lane][wr_cell] <= i_wr.hit;
            end
            if (i_wr.len_we) begin
                r_len[wr_lane]  <= wr_len;
                r_mute[wr_lane] <= i_wr.mute;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.cell_we) begin
            r_mem[wr_addr] <= wr_splice;
        end
        if (i_sp_rd) begin
            r_splice <= r_mem[rd_addr];
        end
    end

    assign o_len     = r_len[i_rd_lane];
    assign o_cell_on = (i_rd_step < LEN_W'(MAX_STEPS)) && !r_mute[i_rd_lane]
                       && r_pat[i_rd_lane][CW'(i_rd_step)];
    assign o_splice  = r_splice;

    a_len_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_len >= LEN_W'(2))
        else $error("loop length below two");

    a_len_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.len_we |=> (r_len[$past(wr_lane)] == $past(wr_len)))
        else $error("lane length not written");

    a_no_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.cell_we && i_wr.len_we))
        else $error("cell and lane write together");

endmodule
